[design/frequency_code_compand_unit_assert.svh]
// Assertion macros for the frequency code compand unit checks.
`ifndef FREQUENCY_CODE_COMPAND_UNIT_ASSERT_SVH
`define FREQUENCY_CODE_COMPAND_UNIT_ASSERT_SVH

// Same-cycle implication, off during reset.
`define FCC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("frequency code compand check failed");

// Next-cycle implication, off during reset.
`define FCC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("frequency code compand check failed");

// Next-cycle implication that also holds across reset.
`define FCC_ASSERT_ALWAYS_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("frequency code compand check failed");

`endif

[design/fcc_pkg.sv]
// Shared constants and types of the frequency code compand unit.
`timescale 1ns / 1ps
package fcc_pkg;

  localparam int VALUE_W    = 31;
  localparam int RESULT_W   = 13;
  localparam int WORD_W     = 14;
  localparam int H_W        = 12;
  localparam int CNT_W      = 4;
  localparam int SQRT_STEPS = 6;
  localparam int DIV_STEPS  = 12;
  localparam int MUL_STEPS  = 6;

  localparam int CODE_OFF    = 127;
  localparam int CODE_CAP    = 126;
  localparam int SMALL_LIMIT = 4;
  // any count at or above this compresses to the cap
  localparam int SAT_LIMIT   = 2048;

  localparam logic REQ_COMPRESS = 1'b0;
  localparam logic REQ_EXPAND   = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic  sub;
    word_t a;
    word_t b;
  } fcc_alu_in_t;

  typedef struct packed {
    logic                       valid;
    logic signed [RESULT_W-1:0] result;
    logic                       range_error;
  } fcc_done_t;

endpackage

[design/fcc_req_if.sv]
// Request channel: conversion type and value.
`timescale 1ns / 1ps
interface fcc_req_if;
  logic                                valid;
  logic                                ready;
  logic                                req_type;
  logic signed [fcc_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink (input valid, input req_type, input value, output ready);
endinterface

[design/fcc_rsp_if.sv]
// Response channel: converted result and range error flag.
`timescale 1ns / 1ps
interface fcc_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [fcc_pkg::RESULT_W-1:0] result;
  logic                                range_error;

  modport source (output valid, output result, output range_error, input ready);
  modport sink (input valid, input result, input range_error, output ready);
endinterface

[design/fcc_alu.sv]
// Shared add/subtract unit with borrow flag.
`timescale 1ns / 1ps
module fcc_alu (
  input  fcc_pkg::fcc_alu_in_t op,
  output fcc_pkg::word_t       y,
  output logic                 neg
);
  import fcc_pkg::*;

  logic [WORD_W:0] full;

  always_comb begin
    if (op.sub) begin
      full = {1'b0, op.a} - {1'b0, op.b};
    end else begin
      full = {1'b0, op.a} + {1'b0, op.b};
    end
  end

  assign y   = full[WORD_W-1:0];
  assign neg = op.sub & full[WORD_W];
endmodule

[design/fcc_seq.sv]
// Sequencer: square root, division and multiply steps over the shared unit.
`timescale 1ns / 1ps
module fcc_seq (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic                               req_type,
  input  logic signed [fcc_pkg::VALUE_W-1:0] value,
  input  logic                               take,
  output logic                               idle,
  output fcc_pkg::fcc_done_t                 done
);
  import fcc_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQRT = 4'd1;
  localparam logic [3:0] ST_RND  = 4'd2;
  localparam logic [3:0] ST_DIV  = 4'd3;
  localparam logic [3:0] ST_ADDQ = 4'd4;
  localparam logic [3:0] ST_SUB2 = 4'd5;
  localparam logic [3:0] ST_ESUB = 4'd6;
  localparam logic [3:0] ST_EINC = 4'd7;
  localparam logic [3:0] ST_MUL  = 4'd8;
  localparam logic [3:0] ST_EADD = 4'd9;
  localparam logic [3:0] ST_DONE = 4'd10;

  localparam logic [3:0] SQRT_TOP = 4'(2 * (SQRT_STEPS - 1));

  logic [3:0]                 state, state_next;
  word_t                      acc, acc_next;
  word_t                      opa, opa_next;
  logic [H_W-1:0]             opb, opb_next;
  logic [H_W-1:0]             quo, quo_next;
  logic [CNT_W-1:0]           cnt, cnt_next;
  logic signed [RESULT_W-1:0] res, res_next;
  logic                       err, err_next;

  fcc_alu_in_t    alu_in;
  word_t          alu_y;
  logic           alu_neg;
  word_t          bitv;
  word_t          partial;
  logic [3:0]     sh;
  logic           neg_in;
  logic [VALUE_W-2:0] mag;

  fcc_alu u_alu (
    .op  (alu_in),
    .y   (alu_y),
    .neg (alu_neg)
  );

  assign sh      = SQRT_TOP - {cnt[2:0], 1'b0};
  assign bitv    = word_t'(1) << sh;
  assign partial = {acc[WORD_W-2:0], opb[H_W-1]};
  assign neg_in  = value[VALUE_W-1];
  assign mag     = value[VALUE_W-2:0];

  always_comb begin
    alu_in.sub = 1'b0;
    alu_in.a   = '0;
    alu_in.b   = '0;
    unique case (state)
      ST_SQRT: begin
        alu_in.sub = 1'b1;
        alu_in.a   = acc;
        alu_in.b   = opa | bitv;
      end
      ST_RND: begin
        alu_in.a = opa;
        alu_in.b = word_t'(1);
      end
      ST_DIV: begin
        alu_in.sub = 1'b1;
        alu_in.a   = partial;
        alu_in.b   = opa;
      end
      ST_ADDQ: begin
        alu_in.a = opa;
        alu_in.b = {{(WORD_W-H_W){1'b0}}, quo};
      end
      ST_SUB2: begin
        alu_in.sub = 1'b1;
        alu_in.a   = acc;
        alu_in.b   = word_t'(2);
      end
      ST_ESUB: begin
        alu_in.sub = 1'b1;
        alu_in.a   = acc;
        alu_in.b   = {{(WORD_W-H_W-1){1'b0}}, quo, 1'b0};
      end
      ST_EINC: begin
        alu_in.a = {{(WORD_W-H_W){1'b0}}, quo};
        alu_in.b = word_t'(1);
      end
      ST_MUL: begin
        alu_in.a = acc;
        alu_in.b = opa;
      end
      ST_EADD: begin
        alu_in.a = acc;
        alu_in.b = {{(WORD_W-H_W+1){1'b0}}, quo[H_W-1:1]};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    acc_next   = acc;
    opa_next   = opa;
    opb_next   = opb;
    quo_next   = quo;
    cnt_next   = cnt;
    res_next   = res;
    err_next   = err;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          err_next = 1'b0;
          res_next = '0;
          cnt_next = '0;
          state_next = ST_DONE;
          if (req_type == REQ_COMPRESS) begin
            if (neg_in && (value != '1)) begin
              err_next = 1'b1;
            end else if (neg_in) begin
              res_next = RESULT_W'(CODE_OFF);
            end else if (mag <= (VALUE_W-1)'(SMALL_LIMIT)) begin
              res_next = value[RESULT_W-1:0];
            end else if (mag >= (VALUE_W-1)'(SAT_LIMIT)) begin
              res_next = RESULT_W'(CODE_CAP);
            end else begin
              opb_next   = {value[H_W-2:0], 1'b0};
              acc_next   = {{(WORD_W-H_W){1'b0}}, value[H_W-2:0], 1'b1};
              opa_next   = '0;
              state_next = ST_SQRT;
            end
          end else begin
            if (neg_in || (mag > (VALUE_W-1)'(CODE_OFF))) begin
              err_next = 1'b1;
            end else if (mag == (VALUE_W-1)'(CODE_OFF)) begin
              res_next = '1;
            end else if (mag <= (VALUE_W-1)'(SMALL_LIMIT)) begin
              res_next = value[RESULT_W-1:0];
            end else begin
              acc_next   = {{(WORD_W-7){1'b0}}, value[6:0]};
              quo_next   = {{(H_W-5){1'b0}}, value[6:2]};
              state_next = ST_ESUB;
            end
          end
        end
      end
      ST_SQRT: begin
        if (!alu_neg) begin
          acc_next = alu_y;
          opa_next = (opa >> 1) | bitv;
        end else begin
          opa_next = opa >> 1;
        end
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
          state_next = ST_RND;
        end
      end
      ST_RND: begin
        opa_next   = alu_y & ~word_t'(1);
        acc_next   = '0;
        quo_next   = '0;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        acc_next = alu_neg ? partial : alu_y;
        quo_next = {quo[H_W-2:0], ~alu_neg};
        opb_next = opb << 1;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_ADDQ;
        end
      end
      ST_ADDQ: begin
        acc_next   = alu_y;
        state_next = ST_SUB2;
      end
      ST_SUB2: begin
        if (alu_y > word_t'(CODE_CAP)) begin
          res_next = RESULT_W'(CODE_CAP);
        end else begin
          res_next = alu_y[RESULT_W-1:0];
        end
        state_next = ST_DONE;
      end
      ST_ESUB: begin
        opa_next   = alu_y;
        state_next = ST_EINC;
      end
      ST_EINC: begin
        opb_next   = alu_y[H_W-1:0];
        acc_next   = '0;
        cnt_next   = '0;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (opb[0]) begin
          acc_next = alu_y;
        end
        opa_next = opa << 1;
        opb_next = opb >> 1;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(MUL_STEPS - 1)) begin
          state_next = ST_EADD;
        end
      end
      ST_EADD: begin
        res_next   = alu_y[RESULT_W-1:0];
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    acc <= acc_next;
    opa <= opa_next;
    opb <= opb_next;
    quo <= quo_next;
    cnt <= cnt_next;
    res <= res_next;
    err <= err_next;
  end

  assign idle              = (state == ST_IDLE);
  assign done.valid        = (state == ST_DONE);
  assign done.result       = res;
  assign done.range_error  = err;
endmodule

[design/frequency_code_compand_unit.sv]
// Top level of the frequency code compand unit.
//
// Channels: req carries req_type (0 compress a usage count, 1 expand a
// 7-bit code) and value; rsp carries result and range_error. Both use a
// valid/ready handshake and move a request at an edge where both are high.
// Each request yields exactly one response.
//
// Out-of-range values, the off marker and the small pass-through values go
// straight to the done state; an expand runs the multiply steps and a
// compress the square-root and division steps. The sequencer takes the
// next request only after the result has moved to the output register.
// All steps run through the one shared adder: six square-root steps,
// twelve restoring division steps and six shift-add multiply steps, one
// per cycle.
//
// Reset (rst, synchronous) returns the sequencer to idle and empties the
// output register. When the receiver stalls, the response holds in the
// output register and the sequencer may take and finish one more request,
// which then waits until the output register frees.
`timescale 1ns / 1ps
module frequency_code_compand_unit (
  input  logic      clk,
  input  logic      rst,
  fcc_req_if.sink   req,
  fcc_rsp_if.source rsp
);
  import fcc_pkg::*;

  fcc_done_t                  done;
  logic                       idle;
  logic                       start;
  logic                       load;
  logic                       out_valid;
  logic signed [RESULT_W-1:0] out_result;
  logic                       out_err;

  assign req.ready = idle;
  assign start     = req.valid & idle;
  assign load      = done.valid & (~out_valid | rsp.ready);

  fcc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req.req_type),
    .value    (req.value),
    .take     (load),
    .idle     (idle),
    .done     (done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
    if (load) begin
      out_result <= done.result;
      out_err    <= done.range_error;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.result      = out_result;
  assign rsp.range_error = out_err;
endmodule

[design/fcc_checker.sv]
// Port-level checks of the frequency code compand unit and their binding.
`timescale 1ns / 1ps
`include "frequency_code_compand_unit_assert.svh"
module fcc_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic signed [fcc_pkg::RESULT_W-1:0] rsp_result,
  input logic                               rsp_range_error
);
  import fcc_pkg::*;

  `FCC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_result) && $stable(rsp_range_error))
  `FCC_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)
  `FCC_ASSERT_NOW(a_err_zero, rsp_valid && rsp_range_error, rsp_result == '0)
  `FCC_ASSERT_ALWAYS_NEXT(a_reset_empty, rst, !rsp_valid)
endmodule

bind frequency_code_compand_unit fcc_checker u_fcc_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_result      (rsp.result),
  .rsp_range_error (rsp.range_error)
);
